FILE: sv/pats_pkg.sv
// shared types and constants for the alarm tone sequencer
`default_nettype none

package pats_pkg;

    localparam int unsigned SLOTS_DEF      = 8;
    localparam int unsigned TONES_DEF      = 16;
    localparam int unsigned LEVEL_BITS_DEF = 3;

    localparam int unsigned TICK_W         = 10;
    localparam logic [TICK_W-1:0] TICK_RESET = 10'd10;

    localparam int unsigned LEN_W  = 5;
    localparam int unsigned EL_W   = 17;
    localparam int unsigned DUR_W  = 16;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_ATTACH = 2'd1,
        REQ_DETACH = 2'd2,
        REQ_LOAD   = 2'd3
    } t_req_e;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [2:0]       slot;
        logic [2:0]       level;
        logic [3:0]       tone_index;
        logic [DUR_W-1:0] tone_duration;
        logic             tone_beep;
        logic [LEN_W-1:0] seq_length;
    } t_in_item;

    typedef struct packed {
        logic       beep_on;
        logic       playing;
        logic [2:0] current_slot;
    } t_out_item;

    typedef struct packed {
        logic             beep;
        logic [DUR_W-1:0] duration;
    } t_tone;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] pos;
        logic [EL_W-1:0]  elapsed;
    } t_slot_ent;

endpackage

`default_nettype wire

FILE: sv/prioritized_alarm_tone_sequencer.sv
// top level: request sequencer around the slot state and tone store memories
//
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    t_in_item
// out      output     o_out_valid / i_out_ready  t_out_item
// cfg      input      i_cfg_valid / o_cfg_ready  tick_ms, 10 bits
//
// a tick steps through accept, slot memory read, tone memory read, winner
// and result; attach, detach, load and an idle tick skip the tone memory read
// the chain of slot memory read then tone memory read makes a playing tick the longest
// reset clears the slot valid bits at once, no clearing pass; tone store is not cleared
// a result waits in the output register; the next item is taken meanwhile
// but its result holds in the final step until the output register frees
`default_nettype none

module prioritized_alarm_tone_sequencer
    import pats_pkg::*;
#(
    parameter int unsigned SLOTS      = SLOTS_DEF,
    parameter int unsigned TONES      = TONES_DEF,
    parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire t_in_item     i_in,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output t_out_item         o_out,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire [TICK_W-1:0]  i_cfg_data
);

    localparam int unsigned SW = $clog2(SLOTS);
    localparam int unsigned AW = $clog2(SLOTS * TONES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SLOT,
        S_TONE,
        S_PICK
    } t_state_e;

    t_state_e                        r_state;
    t_in_item                        r_req;
    logic [SLOTS-1:0]                r_active;
    logic [SLOTS-1:0][LEVEL_BITS-1:0] r_level;
    logic                            r_win_act;
    logic [SW-1:0]                   r_win_slot;
    logic [LEN_W-1:0]                r_pos;
    logic                            r_beep;
    logic [TICK_W-1:0]               r_tick;
    logic                            r_out_valid;
    t_out_item                       r_out;

    logic                            w_in_acc;
    logic                            w_slot_ok;
    logic                            w_load_ok;
    logic                            w_pick_act;
    logic [SW-1:0]                   w_pick_slot;

    logic                            sm_rd_en;
    logic [SW-1:0]                   sm_rd_addr;
    t_slot_ent                       sm_rd_data;
    logic                            sm_we;
    logic [SW-1:0]                   sm_wr_addr;
    t_slot_ent                       sm_wr_data;

    logic                            tm_en;
    logic                            tm_we;
    logic [AW-1:0]                   tm_addr;
    t_tone                           tm_wdata;
    t_tone                           tm_rdata;

    logic [LEN_W-1:0]                w_len;
    logic [LEN_W-1:0]                w_pos_wrap;
    logic                            w_play;
    logic [EL_W:0]                   w_sum;
    logic [EL_W-1:0]                 w_el;
    logic                            w_adv;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_slot_ok = (32'(r_req.slot) < 32'(SLOTS));
    assign w_load_ok = w_slot_ok && (32'(r_req.tone_index) < 32'(TONES));

    // tick step values
    assign w_len      = sm_rd_data.length;
    assign w_pos_wrap = (sm_rd_data.pos > w_len - 5'd1) ? '0 : sm_rd_data.pos;
    assign w_play     = r_win_act && (w_len != '0);
    assign w_sum      = {1'b0, sm_rd_data.elapsed} + (EL_W+1)'(r_tick);
    assign w_el       = w_sum[EL_W] ? '1 : w_sum[EL_W-1:0];
    assign w_adv      = (w_el >= {1'b0, tm_rdata.duration});

    always_comb begin
        sm_rd_en   = 1'b0;
        sm_rd_addr = r_win_slot;
        sm_we      = 1'b0;
        sm_wr_addr = r_win_slot;
        sm_wr_data = sm_rd_data;
        tm_en      = 1'b0;
        tm_we      = 1'b0;
        tm_addr    = AW'(r_win_slot) * AW'(TONES) + AW'(w_pos_wrap);
        tm_wdata   = '{beep: r_req.tone_beep, duration: r_req.tone_duration};
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.req_type == REQ_TICK) begin
                        sm_rd_en = 1'b1;
                    end else if (32'(i_in.slot) < 32'(SLOTS)) begin
                        sm_rd_en   = 1'b1;
                        sm_rd_addr = SW'(i_in.slot);
                    end
                end
            end
            S_SLOT: begin
                if (r_req.req_type == REQ_TICK) begin
                    tm_en = w_play;
                end else if (r_req.req_type == REQ_LOAD && w_load_ok) begin
                    tm_en      = 1'b1;
                    tm_we      = 1'b1;
                    tm_addr    = AW'(r_req.slot) * AW'(TONES) + AW'(r_req.tone_index);
                    sm_we      = 1'b1;
                    sm_wr_addr = SW'(r_req.slot);
                    sm_wr_data.length = (9'(r_req.seq_length) > 9'(TONES)) ?
                                        LEN_W'(TONES) : r_req.seq_length;
                end
            end
            S_TONE: begin
                sm_we              = 1'b1;
                sm_wr_data.pos     = w_adv ? r_pos + 5'd1 : r_pos;
                sm_wr_data.elapsed = w_adv ? '0 : w_el;
            end
            default: begin
            end
        endcase
    end

    pats_slot_mem #(
        .SLOTS     (SLOTS)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (sm_rd_en),
        .i_rd_addr (sm_rd_addr),
        .o_rd_data (sm_rd_data),
        .i_we      (sm_we),
        .i_wr_addr (sm_wr_addr),
        .i_wr_data (sm_wr_data)
    );

    pats_tone_mem #(
        .DEPTH   (SLOTS * TONES)
    ) u_tone_mem (
        .i_clk   (i_clk),
        .i_en    (tm_en),
        .i_we    (tm_we),
        .i_addr  (tm_addr),
        .i_wdata (tm_wdata),
        .o_rdata (tm_rdata)
    );

    pats_pick #(
        .SLOTS      (SLOTS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_pick (
        .i_active   (r_active),
        .i_level    (r_level),
        .o_win_act  (w_pick_act),
        .o_win_slot (w_pick_slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_level     <= '0;
            r_win_act   <= 1'b0;
            r_win_slot  <= '0;
            r_beep      <= 1'b0;
            r_tick      <= TICK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tick <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready && r_state != S_PICK) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_req   <= i_in;
                        r_state <= S_SLOT;
                    end
                end
                S_SLOT: begin
                    if (r_req.req_type == REQ_TICK) begin
                        if (w_play) begin
                            r_pos   <= w_pos_wrap;
                            r_state <= S_TONE;
                        end else begin
                            r_beep  <= 1'b0;
                            r_state <= S_PICK;
                        end
                    end else begin
                        r_state <= S_PICK;
                        if (w_slot_ok) begin
                            if (r_req.req_type == REQ_ATTACH) begin
                                r_active[SW'(r_req.slot)] <= 1'b1;
                                r_level[SW'(r_req.slot)]  <= LEVEL_BITS'(r_req.level);
                            end else if (r_req.req_type == REQ_DETACH) begin
                                r_active[SW'(r_req.slot)] <= 1'b0;
                            end
                        end
                    end
                end
                S_TONE: begin
                    r_beep  <= tm_rdata.beep;
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_win_act          <= w_pick_act;
                        r_win_slot         <= w_pick_slot;
                        r_out.beep_on      <= r_beep;
                        r_out.playing      <= w_pick_act;
                        r_out.current_slot <= w_pick_act ? 3'(w_pick_slot) : 3'd0;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_out_from_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_PICK))
        else $error("result raised outside the final step");

    a_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.playing) |-> (o_out.current_slot == 3'd0))
        else $error("slot reported while nothing plays");

    a_tone_has_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TONE) |-> r_win_act)
        else $error("tone read without an active slot");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_SLOT))
        else $error("accepted item did not start the slot read");

endmodule

`default_nettype wire

FILE: sv/pats_tone_mem.sv
// tone store: single-port synchronous memory, one entry per slot and tone
`default_nettype none

module pats_tone_mem
    import pats_pkg::*;
#(
    parameter int unsigned DEPTH = SLOTS_DEF * TONES_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_en,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_addr,
    input  wire t_tone                i_wdata,
    output t_tone                     o_rdata
);

    t_tone r_mem [DEPTH];
    t_tone r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/pats_slot_mem.sv
// per-slot playback state memory with reset-cleared valid bits
`default_nettype none

module pats_slot_mem
    import pats_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_rd_en,
    input  wire [$clog2(SLOTS)-1:0]   i_rd_addr,
    output t_slot_ent                 o_rd_data,
    input  wire                       i_we,
    input  wire [$clog2(SLOTS)-1:0]   i_wr_addr,
    input  wire t_slot_ent            i_wr_data
);

    t_slot_ent        r_mem [SLOTS];
    logic [SLOTS-1:0] r_vld;
    t_slot_ent        r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: sv/pats_pick.sv
// priority tree: highest active level wins, ties to the lowest slot
`default_nettype none

module pats_pick
    import pats_pkg::*;
#(
    parameter int unsigned SLOTS      = SLOTS_DEF,
    parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  wire [SLOTS-1:0]                 i_active,
    input  wire [SLOTS-1:0][LEVEL_BITS-1:0] i_level,
    output logic                            o_win_act,
    output logic [$clog2(SLOTS)-1:0]        o_win_slot
);

    localparam int unsigned SW = $clog2(SLOTS);
    localparam int unsigned NP = 1 << SW;

    typedef struct packed {
        logic                  act;
        logic [LEVEL_BITS-1:0] lvl;
        logic [SW-1:0]         idx;
    } t_node;

    t_node w_nd [SW+1][NP];

    always_comb begin
        w_nd = '{default: '0};
        for (int i = 0; i < NP; i++) begin
            if (i < SLOTS) begin
                w_nd[0][i].act = i_active[i];
                w_nd[0][i].lvl = i_level[i];
                w_nd[0][i].idx = SW'(i);
            end
        end
        for (int l = 0; l < SW; l++) begin
            for (int j = 0; j < NP / 2; j++) begin
                if (j < (NP >> (l + 1))) begin
                    if (w_nd[l][2*j+1].act &&
                        (!w_nd[l][2*j].act || w_nd[l][2*j+1].lvl > w_nd[l][2*j].lvl)) begin
                        w_nd[l+1][j] = w_nd[l][2*j+1];
                    end else begin
                        w_nd[l+1][j] = w_nd[l][2*j];
                    end
                end
            end
        end
    end

    assign o_win_act  = w_nd[SW][0].act;
    assign o_win_slot = w_nd[SW][0].idx;

endmodule

`default_nettype wire

FILE: sim/tb_prioritized_alarm_tone_sequencer.sv
// self-checking testbench for the prioritised alarm tone sequencer
module tb_prioritized_alarm_tone_sequencer;
    import pats_pkg::*;

    localparam int SLOT_COUNT  = SLOTS_DEF;
    localparam int TONE_COUNT  = TONES_DEF;
    localparam int ELAPSED_MAX = (1 << EL_W) - 1;
    localparam int DRAIN_GAP   = 8;
    localparam int STALL_LIMIT = 4000;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in        = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [TICK_W-1:0] i_cfg_data  = '0;

    prioritized_alarm_tone_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // predicted sequencer state
    bit                slot_on      [SLOT_COUNT];
    int                slot_prio    [SLOT_COUNT];
    int                slot_len     [SLOT_COUNT];
    int                slot_pos     [SLOT_COUNT];
    int                slot_elapsed [SLOT_COUNT];
    t_tone             tone_mem     [SLOT_COUNT][TONE_COUNT];
    bit                tone_set     [SLOT_COUNT][TONE_COUNT];
    bit                buzzer       = 1'b0;
    logic [TICK_W-1:0] tick_interval = TICK_RESET;

    t_out_item expected_outputs[$];

    int send_idle_pct = 11;
    int recv_idle_pct = 79;
    int error_count   = 0;
    int stall_cycles  = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int top_slot();
        int best;
        best = -1;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (slot_on[s] && (best < 0 || slot_prio[s] > slot_prio[best])) begin
                best = s;
            end
        end
        return best;
    endfunction

    function automatic t_out_item step_alarm_state(input t_in_item it);
        int        w;
        int        pos;
        int        e;
        t_tone     tone;
        t_out_item r;
        case (it.req_type)
            REQ_TICK: begin
                w = top_slot();
                if (w < 0 || slot_len[w] == 0) begin
                    buzzer = 1'b0;
                end else begin
                    pos = slot_pos[w];
                    if (pos > slot_len[w] - 1) begin
                        pos = 0;
                    end
                    tone = tone_mem[w][pos];
                    e = slot_elapsed[w] + int'(tick_interval);
                    if (e > ELAPSED_MAX) begin
                        e = ELAPSED_MAX;
                    end
                    if (e >= int'(tone.duration)) begin
                        pos++;
                        e = 0;
                    end
                    slot_pos[w]     = pos;
                    slot_elapsed[w] = e;
                    buzzer          = tone.beep;
                end
            end
            REQ_ATTACH: begin
                slot_on[it.slot]   = 1'b1;
                slot_prio[it.slot] = it.level;
            end
            REQ_DETACH: begin
                slot_on[it.slot] = 1'b0;
            end
            default: begin
                tone_mem[it.slot][it.tone_index] = '{beep: it.tone_beep,
                                                     duration: it.tone_duration};
                tone_set[it.slot][it.tone_index] = 1'b1;
                slot_len[it.slot] = (it.seq_length > TONE_COUNT) ? TONE_COUNT
                                                                 : it.seq_length;
            end
        endcase
        w = top_slot();
        r.beep_on      = buzzer;
        r.playing      = (w >= 0);
        r.current_slot = (w >= 0) ? 3'(w) : 3'd0;
        return r;
    endfunction

    // a tick must never read a tone entry that has not been written
    function automatic bit tick_hits_blank_entry(output t_in_item fill);
        int w;
        int pos;
        fill = '0;
        w = top_slot();
        if (w < 0 || slot_len[w] == 0) begin
            return 1'b0;
        end
        pos = slot_pos[w];
        if (pos > slot_len[w] - 1) begin
            pos = 0;
        end
        if (tone_set[w][pos]) begin
            return 1'b0;
        end
        fill.req_type      = REQ_LOAD;
        fill.slot          = 3'(w);
        fill.level         = 3'($urandom_range(7));
        fill.tone_index    = 4'(pos);
        fill.tone_duration = 16'($urandom_range(4 * int'(tick_interval) + 2));
        fill.tone_beep     = 1'($urandom_range(1));
        fill.seq_length    = 5'(slot_len[w]);
        return 1'b1;
    endfunction

    function automatic t_in_item make_req(input t_req_e kind, input int slot_no,
                                          input int lvl, input int idx, input int dur,
                                          input int beep, input int len);
        t_in_item it;
        it.req_type      = kind;
        it.slot          = 3'(slot_no);
        it.level         = 3'(lvl);
        it.tone_index    = 4'(idx);
        it.tone_duration = 16'(dur);
        it.tone_beep     = 1'(beep);
        it.seq_length    = 5'(len);
        return it;
    endfunction

    function automatic t_in_item random_request();
        t_in_item it;
        int       pick;
        it.slot          = 3'($urandom_range(7));
        it.level         = 3'($urandom_range(7));
        it.tone_index    = 4'($urandom_range(15));
        it.tone_duration = 16'($urandom_range(65535));
        it.tone_beep     = 1'($urandom_range(1));
        it.seq_length    = 5'($urandom_range(31));
        pick = $urandom_range(99);
        if (pick < 55) begin
            it.req_type = REQ_TICK;
        end else if (pick < 70) begin
            it.req_type = REQ_ATTACH;
        end else if (pick < 78) begin
            it.req_type = REQ_DETACH;
        end else begin
            it.req_type = REQ_LOAD;
            if ($urandom_range(3) != 0) begin
                it.tone_duration = 16'($urandom_range(4 * int'(tick_interval) + 2));
            end
            if ($urandom_range(9) != 0) begin
                it.seq_length = 5'($urandom_range(TONE_COUNT, 1));
            end
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_item(input t_in_item item);
        t_out_item predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = step_alarm_state(item);
        expected_outputs.insert(expected_outputs.size(), predicted);
    endtask

    task automatic issue(input t_in_item item);
        t_in_item fill;
        if (item.req_type == REQ_TICK) begin
            while (tick_hits_blank_entry(fill)) begin
                send_item(fill);
            end
        end
        send_item(item);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic set_tick_interval(input logic [TICK_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tick_interval = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        issue(make_req(REQ_TICK,   0, 0,  0,     0, 0,  0));
        issue(make_req(REQ_ATTACH, 0, 0,  0,     0, 0,  0));
        issue(make_req(REQ_TICK,   0, 0,  0,     0, 0,  0));
        issue(make_req(REQ_LOAD,   0, 0,  0,     0, 1,  1));
        issue(make_req(REQ_TICK,   0, 0,  0,     0, 0,  0));
        issue(make_req(REQ_TICK,   0, 0,  0,     0, 0,  0));
        issue(make_req(REQ_LOAD,   7, 0, 15, 65535, 1, 31));
        issue(make_req(REQ_ATTACH, 7, 7,  0,     0, 0,  0));
        issue(make_req(REQ_TICK,   0, 0,  0,     0, 0,  0));
        issue(make_req(REQ_ATTACH, 3, 7,  0,     0, 0,  0));
        issue(make_req(REQ_TICK,   0, 0,  0,     0, 0,  0));
        issue(make_req(REQ_ATTACH, 3, 2,  0,     0, 0,  0));
        issue(make_req(REQ_DETACH, 7, 0,  0,     0, 0,  0));
        issue(make_req(REQ_LOAD,   5, 0,  0,     0, 1,  3));
        issue(make_req(REQ_LOAD,   5, 0,  1,     0, 0,  3));
        issue(make_req(REQ_LOAD,   5, 0,  2,     0, 1,  3));
        issue(make_req(REQ_ATTACH, 5, 6,  0,     0, 0,  0));
        issue(make_req(REQ_TICK,   0, 0,  0,     0, 0,  0));
        issue(make_req(REQ_TICK,   0, 0,  0,     0, 0,  0));
        // shortened sequence leaves the position past the end
        issue(make_req(REQ_LOAD,   5, 0,  0,     0, 0,  1));
        issue(make_req(REQ_TICK,   0, 0,  0,     0, 0,  0));
        issue(make_req(REQ_DETACH, 5, 0,  0,     0, 0,  0));
        issue(make_req(REQ_DETACH, 3, 0,  0,     0, 0,  0));
        issue(make_req(REQ_DETACH, 0, 0,  0,     0, 0,  0));
        issue(make_req(REQ_TICK,   0, 0,  0,     0, 0,  0));
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++) begin
            issue(random_request());
        end
    endtask

    task automatic test_pause_until_drained();
        test_random_traffic(20);
        wait_drained();
        test_random_traffic(20);
    endtask

    initial begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_on[s]      = 1'b0;
            slot_prio[s]    = 0;
            slot_len[s]     = 0;
            slot_pos[s]     = 0;
            slot_elapsed[s] = 0;
            for (int t = 0; t < TONE_COUNT; t++) begin
                tone_mem[s][t] = '0;
                tone_set[s][t] = 1'b0;
            end
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        set_tick_interval(10'd1);
        test_random_traffic(150);
        test_pause_until_drained();

        send_idle_pct = 79;
        recv_idle_pct = 11;
        set_tick_interval(10'd1000);
        test_random_traffic(200);
        set_tick_interval(10'd0);
        test_random_traffic(60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_tick_interval(10'd1023);
        test_random_traffic(80);
        set_tick_interval(10'($urandom_range(999, 2)));
        test_random_traffic(170);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (expected_outputs.size() != 0) begin
            report_mismatch("results still outstanding", expected_outputs.size(), 0);
        end
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch("result with none expected", o_out, 0);
            end else begin
                want = expected_outputs.pop_front();
                if (o_out.beep_on !== want.beep_on) begin
                    report_mismatch("beep_on", o_out.beep_on, want.beep_on);
                end
                if (o_out.playing !== want.playing) begin
                    report_mismatch("playing", o_out.playing, want.playing);
                end
                if (o_out.current_slot !== want.current_slot) begin
                    report_mismatch("current_slot", o_out.current_slot, want.current_slot);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
